@@ design/sbr_pkg.sv @@
// shared types, constants and helpers for the sbus frame receiver
`timescale 1ns / 1ps

package sbr_pkg;

  // frame geometry
  localparam int unsigned NUM_CH     = 16;
  localparam int unsigned CH_W       = 11;
  localparam int unsigned CH_BITS    = NUM_CH * CH_W;   // 176 packed channel bits
  localparam int unsigned STORE_LEN  = 23;              // data bytes between header and footer
  localparam int unsigned STORE_BITS = STORE_LEN * 8;
  localparam int unsigned FLAG_W     = 4;
  localparam int unsigned FLAG_LSB   = (STORE_LEN - 1) * 8;

  // byte position inside a frame; idle waits for header, last is the footer word
  localparam logic [4:0] POS_IDLE = 5'd0;
  localparam logic [4:0] POS_LAST = 5'd24;

  // queue of decoded frames between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // register indexes on the configuration port
  localparam logic [1:0] REG_HEADER        = 2'd0;
  localparam logic [1:0] REG_FOOTER        = 2'd1;
  localparam logic [1:0] REG_FOOTER_NIBBLE = 2'd2;

  // one complete frame handed from front to back
  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [CH_BITS-1:0] bits;
  } frame_t;

  // queue handshake from queue to back
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } qhead_t;

  // frame end test: full footer byte or footer nibble in the low four bits
  function automatic logic is_footer(input logic [7:0] b, input logic [7:0] fv,
                                     input logic [3:0] fn);
    is_footer = (b == fv) || (b[3:0] == fn);
  endfunction

endpackage

@@ design/sbus_frame_receiver.sv @@
// Serial-bus frame receiver: one byte word in per cycle, sixteen channel words out per frame.
// A good footer queues its frame; the back end loads it and registers out its channel words.
// Throughput: one byte word per cycle in when not stalled; one channel word per cycle out when
// out_stall is low, plus an idle gap between frames as the back end loads from the two-frame queue.
// Input stalls only on a footer word while two decoded frames still wait in the queue.
// Reset (synchronous): framing goes idle, queue empties, registers return to defaults.
`timescale 1ns / 1ps

module sbus_frame_receiver import sbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // channel output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        digital_one,
  output logic        digital_two,
  output logic        lost_frame,
  output logic        fail_safe,
  output logic        last_channel
);

  logic [7:0] header_value;
  logic [7:0] footer_value;
  logic [3:0] footer_nibble;
  logic       cfg_wr;
  logic       q_full;
  logic       push;
  frame_t     push_frame;
  logic       pop;
  qhead_t     head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= 8'h0F;
      footer_value  <= 8'h00;
      footer_nibble <= 4'h4;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HEADER:        header_value  <= pwdata[7:0];
        REG_FOOTER:        footer_value  <= pwdata[7:0];
        REG_FOOTER_NIBBLE: footer_nibble <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER:        prdata = {24'd0, header_value};
      REG_FOOTER:        prdata = {24'd0, footer_value};
      REG_FOOTER_NIBBLE: prdata = {28'd0, footer_nibble};
      default:           prdata = 32'd0;
    endcase
  end

  sbr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .header_value  (header_value),
    .footer_value  (footer_value),
    .footer_nibble (footer_nibble),
    .q_full        (q_full),
    .push          (push),
    .push_frame    (push_frame)
  );

  sbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  sbr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .digital_one   (digital_one),
    .digital_two   (digital_two),
    .lost_frame    (lost_frame),
    .fail_safe     (fail_safe),
    .last_channel  (last_channel)
  );

endmodule

@@ design/sbr_front.sv @@
// front end: byte framing, frame capture and footer check
`timescale 1ns / 1ps

module sbr_front import sbr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   header_value,
  input  logic [7:0]   footer_value,
  input  logic [3:0]   footer_nibble,
  input  logic         q_full,
  output logic         push,
  output frame_t       push_frame
);

  logic [4:0]            pos;
  logic [4:0]            pos_next;
  logic [7:0]            prev;
  logic [STORE_BITS-1:0] store;
  logic                  fire;
  logic                  last_pos;

  assign last_pos = (pos == POS_LAST);

  // hold the footer word only while the queue has no room for a frame
  assign in_stall = q_full && last_pos;
  assign fire     = in_valid && !in_stall;

  // a good footer hands the captured frame to the queue
  assign push             = fire && last_pos && is_footer(rx_byte, footer_value, footer_nibble);
  assign push_frame.bits  = store[CH_BITS-1:0];
  assign push_frame.flags = store[FLAG_LSB +: FLAG_W];

  // position sequencing
  always_comb begin
    pos_next = pos;
    if (fire) begin
      if (pos == POS_IDLE) begin
        if (rx_byte == header_value && is_footer(prev, footer_value, footer_nibble)) begin
          pos_next = 5'd1;
        end
      end else if (last_pos) begin
        pos_next = POS_IDLE;
      end else begin
        pos_next = pos + 5'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_IDLE;
      prev <= 8'd0;
    end else begin
      pos <= pos_next;
      if (fire) begin
        prev <= rx_byte;
      end
    end
  end

  // data words shift in from the top; first data word ends at bit 0
  always_ff @(posedge clk) begin
    if (fire && pos != POS_IDLE && !last_pos) begin
      store <= {rx_byte, store[STORE_BITS-1:8]};
    end
  end

endmodule

@@ design/sbr_queue.sv @@
// two-entry queue of decoded frames between front and back
`timescale 1ns / 1ps

module sbr_queue import sbr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

  frame_t             entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full        = (count == QCNT_W'(QDEPTH));
  assign head.valid  = (count != '0);
  assign head.frame  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // frame storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

@@ design/sbr_back.sv @@
// back end: unpacks one frame into sixteen channel words
`timescale 1ns / 1ps

module sbr_back import sbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  qhead_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        digital_one,
  output logic        digital_two,
  output logic        lost_frame,
  output logic        fail_safe,
  output logic        last_channel
);

  logic               busy;
  logic [CH_BITS-1:0] shreg;
  logic [FLAG_W-1:0]  flags;
  logic [3:0]         cnt;
  logic               adv;
  logic               last_cnt;

  assign adv      = !out_valid || !out_stall;
  assign last_cnt = (cnt == 4'(NUM_CH - 1));
  assign pop      = !busy && head.valid;

  // control: frame load, channel count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy && adv) begin
        cnt <= cnt + 4'd1;
        if (last_cnt) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  // channel shifter and output word
  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= head.frame.bits;
      flags <= head.frame.flags;
    end else if (busy && adv) begin
      shreg         <= {{CH_W{1'b0}}, shreg[CH_BITS-1:CH_W]};
      channel_index <= cnt;
      channel_value <= shreg[CH_W-1:0];
      digital_one   <= flags[0];
      digital_two   <= flags[1];
      lost_frame    <= flags[2];
      fail_safe     <= flags[3];
      last_channel  <= last_cnt;
    end
  end

endmodule

@@ tb/sbus_channel_checker.sv @@
// channel word checker: tracks framing registers, predicts decoded channel words, compares
`timescale 1ns / 1ps

module sbus_channel_checker import sbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  channel_index,
  input  logic [10:0] channel_value,
  input  logic        digital_one,
  input  logic        digital_two,
  input  logic        lost_frame,
  input  logic        fail_safe,
  input  logic        last_channel,
  output int          fail_count,
  output int          due_count
);

  // framing register defaults
  localparam logic [7:0] HDR_DEFAULT = 8'h0F;
  localparam logic [7:0] FTR_DEFAULT = 8'h00;
  localparam logic [3:0] NIB_DEFAULT = 4'h4;

  // one decoded channel word
  typedef struct packed {
    logic [3:0]      idx;
    logic [CH_W-1:0] value;
    logic            d_one;
    logic            d_two;
    logic            lost;
    logic            fsafe;
    logic            last;
  } chan_word_t;

  logic [7:0] hdr_reg;
  logic [7:0] ftr_reg;
  logic [3:0] nib_reg;
  logic [4:0] frame_pos;
  logic [7:0] prev_byte;
  logic [7:0] frame_bytes [STORE_LEN];
  chan_word_t channel_words_due [$];
  int         err_tally = 0;

  // frame end test against the current registers
  function automatic logic closes_frame(input logic [7:0] b);
    closes_frame = (b == ftr_reg) || (b[3:0] == nib_reg);
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    $error("%s: expected %0d, actual %0d", field, want, got);
    err_tally++;
  endtask

  // advance the framing state by one byte, queue the sixteen words of a good frame
  task automatic absorb_rx_byte(input logic [7:0] b);
    logic [CH_BITS-1:0] packed_bits;
    chan_word_t         w;
    if (frame_pos == POS_IDLE) begin
      if (b == hdr_reg && closes_frame(prev_byte)) frame_pos = POS_IDLE + 5'd1;
    end else if (frame_pos != POS_LAST) begin
      frame_bytes[frame_pos - 5'd1] = b;
      frame_pos = frame_pos + 5'd1;
    end else begin
      frame_pos = POS_IDLE;
      if (closes_frame(b)) begin
        for (int k = 0; k < STORE_LEN - 1; k++) packed_bits[8*k +: 8] = frame_bytes[k];
        for (int ch = 0; ch < NUM_CH; ch++) begin
          w.idx   = ch[3:0];
          w.value = packed_bits[CH_W*ch +: CH_W];
          w.d_one = frame_bytes[STORE_LEN-1][0];
          w.d_two = frame_bytes[STORE_LEN-1][1];
          w.lost  = frame_bytes[STORE_LEN-1][2];
          w.fsafe = frame_bytes[STORE_LEN-1][3];
          w.last  = (ch == NUM_CH - 1);
          channel_words_due.push_back(w);
        end
      end
    end
    prev_byte = b;
  endtask

  // compare one accepted output word with the oldest expected one
  task automatic check_channel_word();
    chan_word_t want;
    if (channel_words_due.size() == 0) begin
      $error("channel word with nothing expected: index %0d value %0d",
             channel_index, channel_value);
      err_tally++;
    end else begin
      want = channel_words_due.pop_front();
      if (want.idx != channel_index) report_mismatch("channel_index", want.idx, channel_index);
      if (want.value != channel_value) report_mismatch("channel_value", want.value, channel_value);
      if (want.d_one != digital_one) report_mismatch("digital_one", want.d_one, digital_one);
      if (want.d_two != digital_two) report_mismatch("digital_two", want.d_two, digital_two);
      if (want.lost != lost_frame) report_mismatch("lost_frame", want.lost, lost_frame);
      if (want.fsafe != fail_safe) report_mismatch("fail_safe", want.fsafe, fail_safe);
      if (want.last != last_channel) report_mismatch("last_channel", want.last, last_channel);
    end
  endtask

  // watch register port, byte input and channel output
  always @(posedge clk) begin
    if (rst) begin
      hdr_reg = HDR_DEFAULT;
      ftr_reg = FTR_DEFAULT;
      nib_reg = NIB_DEFAULT;
      frame_pos = POS_IDLE;
      prev_byte = 8'h00;
      channel_words_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_HEADER:        hdr_reg = pwdata[7:0];
            REG_FOOTER:        ftr_reg = pwdata[7:0];
            REG_FOOTER_NIBBLE: nib_reg = pwdata[3:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_HEADER:
              if (prdata != {24'd0, hdr_reg}) report_mismatch("header_value", hdr_reg, prdata);
            REG_FOOTER:
              if (prdata != {24'd0, ftr_reg}) report_mismatch("footer_value", ftr_reg, prdata);
            REG_FOOTER_NIBBLE:
              if (prdata != {28'd0, nib_reg}) report_mismatch("footer_nibble", nib_reg, prdata);
            default: ;
          endcase
        end
      end
      if (out_valid && !out_stall) check_channel_word();
      if (in_valid && !in_stall) absorb_rx_byte(rx_byte);
    end
    due_count  <= channel_words_due.size();
    fail_count <= err_tally;
  end

endmodule

@@ tb/testbench.sv @@
// top of the sbus frame receiver bench: clock, reset, byte and register stimulus, verdict
`timescale 1ns / 1ps

module testbench import sbr_pkg::*;;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        digital_one;
  logic        digital_two;
  logic        lost_frame;
  logic        fail_safe;
  logic        last_channel;
  int          fail_count;
  int          due_count;

  int          in_idle_pct;
  int          out_idle_pct;
  bit          hold_req;
  bit          hold_done;
  int          idle_run;
  logic [7:0]  hdr_cur;
  logic [7:0]  ftr_cur;
  logic [3:0]  nib_cur;

  sbus_frame_receiver dut (.*);
  sbus_channel_checker chk (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // output side stall, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // offer one byte word, with random gaps, and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every expected channel word plus settling time
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write all framing registers with junk in the upper bits, poke the spare slot, read back
  task automatic program_framing(input logic [7:0] h, input logic [7:0] f, input logic [3:0] n);
    logic [31:0] junk;
    junk = $urandom;
    apb_access(REG_HEADER, 1'b1, {junk[31:8], h});
    apb_access(REG_FOOTER, 1'b1, {junk[23:0], f});
    apb_access(REG_FOOTER_NIBBLE, 1'b1, {junk[27:0], n});
    apb_access(REG_UNUSED, 1'b1, $urandom);
    apb_access(REG_HEADER, 1'b0, 32'd0);
    apb_access(REG_FOOTER, 1'b0, 32'd0);
    apb_access(REG_FOOTER_NIBBLE, 1'b0, 32'd0);
    hdr_cur = h;
    ftr_cur = f;
    nib_cur = n;
  endtask

  // a byte that passes the frame end test, either variant
  function automatic logic [7:0] footer_like();
    logic [3:0] hi;
    hi = 4'($urandom_range(15));
    footer_like = ($urandom_range(1) != 0) ? ftr_cur : {hi, nib_cur};
  endfunction

  // lead byte, header, random body (header value sprinkled in), good or random end
  task automatic send_frame(input bit clean_end);
    logic [7:0] b;
    send_byte(footer_like());
    send_byte(hdr_cur);
    for (int k = 0; k < STORE_LEN; k++) begin
      b = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) b = hdr_cur;
      send_byte(b);
    end
    if (clean_end) send_byte(footer_like());
    else send_byte(8'($urandom_range(255)));
  endtask

  // a few noise bytes then a mostly well-formed frame
  task automatic random_burst();
    int noise;
    noise = $urandom_range(4);
    repeat (noise) send_byte(8'($urandom_range(255)));
    send_frame($urandom_range(9) != 0);
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 4'd0;
    pwdata       = 32'd0;
    in_valid     = 1'b0;
    rx_byte      = 8'd0;
    hold_req     = 1'b0;
    in_idle_pct  = 30;
    out_idle_pct = 52;
    hdr_cur      = 8'h0F;
    ftr_cur      = 8'h00;
    nib_cur      = 4'h4;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // long output hold-off while the first four frames arrive, so the block fills up
    hold_req = 1'b1;
    // full-scale channels, all flags set, exact footer byte; reset previous byte opens it
    send_byte(hdr_cur);
    repeat (22) send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(ftr_cur);
    // zero channels, only upper flag byte bits set, footer by low nibble
    send_byte(hdr_cur);
    repeat (22) send_byte(8'h00);
    send_byte(8'hF0);
    send_byte({4'hA, nib_cur});
    // header after a non-footer byte is ignored, header value as data
    send_byte(8'h55);
    send_byte(hdr_cur);
    send_byte({4'h3, nib_cur});
    send_byte(hdr_cur);
    for (int k = 0; k < STORE_LEN; k++) send_byte((k % 2) ? hdr_cur : 8'hAA);
    send_byte(ftr_cur);
    // one more clean frame, its footer waits for room in the queue
    send_frame(1'b1);
    // footer register changed partway through a frame; the old footer byte now drops it
    send_byte(ftr_cur);
    send_byte(hdr_cur);
    repeat (10) send_byte(8'($urandom_range(255)));
    drain();
    apb_access(REG_FOOTER, 1'b1, 32'h0000_0099);
    ftr_cur = 8'h99;
    repeat (12) send_byte(8'($urandom_range(255)));
    send_byte(8'h0D);
    send_byte(8'h00);

    // high extremes
    drain();
    program_framing(8'hFF, 8'hFF, 4'hF);
    random_burst();

    // low extremes, idling swapped
    drain();
    in_idle_pct  = 52;
    out_idle_pct = 30;
    program_framing(8'h00, 8'h00, 4'h0);
    random_burst();

    // random settings, no idling
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    program_framing(8'($urandom_range(255)), 8'($urandom_range(255)),
                    4'($urandom_range(15)));
    random_burst();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sbr_pkg.sv
design/sbr_front.sv
design/sbr_queue.sv
design/sbr_back.sv
design/sbus_frame_receiver.sv
tb/sbus_channel_checker.sv
tb/testbench.sv
